@@ hdl/mseu_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mseu_pkg
// Shared types, opcodes and memory sizing for the execute unit.
// ---------------------------------------------------------------------------
package mseu_pkg;

  localparam int MEM_BYTES = 1024;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int ROW_AW    = MEM_AW - 2;
  localparam int ROWS      = MEM_BYTES / 4;

  localparam logic [4:0] REG_LINK = 5'd31;

  localparam logic [5:0] OP_ADD   = 6'd0;
  localparam logic [5:0] OP_ADDU  = 6'd1;
  localparam logic [5:0] OP_SUB   = 6'd2;
  localparam logic [5:0] OP_AND   = 6'd3;
  localparam logic [5:0] OP_OR    = 6'd4;
  localparam logic [5:0] OP_XOR   = 6'd5;
  localparam logic [5:0] OP_NOR   = 6'd6;
  localparam logic [5:0] OP_NAND  = 6'd7;
  localparam logic [5:0] OP_SLT   = 6'd8;
  localparam logic [5:0] OP_SLL   = 6'd9;
  localparam logic [5:0] OP_SRL   = 6'd10;
  localparam logic [5:0] OP_SRA   = 6'd11;
  localparam logic [5:0] OP_JR    = 6'd12;
  localparam logic [5:0] OP_ADDI  = 6'd13;
  localparam logic [5:0] OP_ADDIU = 6'd14;
  localparam logic [5:0] OP_LW    = 6'd15;
  localparam logic [5:0] OP_LH    = 6'd16;
  localparam logic [5:0] OP_LHU   = 6'd17;
  localparam logic [5:0] OP_LB    = 6'd18;
  localparam logic [5:0] OP_LBU   = 6'd19;
  localparam logic [5:0] OP_SW    = 6'd20;
  localparam logic [5:0] OP_SH    = 6'd21;
  localparam logic [5:0] OP_SB    = 6'd22;
  localparam logic [5:0] OP_LUI   = 6'd23;
  localparam logic [5:0] OP_ANDI  = 6'd24;
  localparam logic [5:0] OP_ORI   = 6'd25;
  localparam logic [5:0] OP_NORI  = 6'd26;
  localparam logic [5:0] OP_SLTI  = 6'd27;
  localparam logic [5:0] OP_BEQ   = 6'd28;
  localparam logic [5:0] OP_BNE   = 6'd29;
  localparam logic [5:0] OP_BGTZ  = 6'd30;
  localparam logic [5:0] OP_J     = 6'd31;
  localparam logic [5:0] OP_JAL   = 6'd32;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  typedef struct packed {
    logic [5:0]  op;
    logic [4:0]  src_reg;
    logic [4:0]  tgt_reg;
    logic [4:0]  dst_reg;
    logic [4:0]  shift_amount;
    logic [25:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        write_zero_error;
    logic        number_overflow;
    logic        address_overflow;
    logic        misaligned;
    logic        halt;
  } out_item_t;

endpackage

@@ hdl/mseu_in_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mseu_in_if
// Request channel carrying one decoded instruction.
// ---------------------------------------------------------------------------
interface mseu_in_if;
  import mseu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/mseu_out_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mseu_out_if
// Result channel carrying next PC and status flags.
// ---------------------------------------------------------------------------
interface mseu_out_if;
  import mseu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/mips_subset_execute_unit_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mips_subset_execute_unit_core
// Executes one instruction of a small MIPS-like subset per request.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one decoded instruction per request (valid/ready).
//   out_ch : one result per request: next PC and error flags (valid/ready).
//   APB    : one register, start_pc at byte address 0; a write loads the PC.
//            Write it only while no request is in flight.
// Pipeline: a result passes through stage B, stage C and the output register
//   before it is presented.
// Throughput: one request per cycle while out_ch does not stall. The register
//   file (two read ports) is read on accept, the data memory (32-bit rows) as
//   the request leaves stage B, and the write back happens in stage C; results
//   from that stage are forwarded to the next instruction.
// Reset: registers, data memory and halt read as zero (per-entry valid
//   bits), PC and start_pc are zero. No clearing pass is needed.
// Stall: when out_ch.ready is low while a result is held, the whole pipe
//   holds and in_ch.ready drops.
// A faulting load or store (bad address or alignment) halts the block;
//   every later request answers the held PC with only halt set.
// ---------------------------------------------------------------------------
module mips_subset_execute_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  mseu_in_if.sink     in_ch,
  mseu_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mseu_pkg::*;

  // pipeline control: every stage moves together
  logic advance;
  logic out_valid_r;
  out_item_t out_data_r;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // configuration port
  logic [31:0] start_pc_r;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign prdata = start_pc_r;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

  // ---------------- register file (two read ports, valid bits) -------------
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic [31:0] rf_a_q, rf_b_q;
  logic        a_vld_r, b_vld_r, a_byp_r, b_byp_r;
  logic [31:0] a_bdat_r, b_bdat_r;
  logic        rf_we;
  logic [31:0] rf_wdata;

  // ---------------- stage B: operands ready, compute -----------------------
  logic        b_valid_r;
  in_item_t    b_item_r;
  logic [31:0] pc_r;
  logic        halted_r;

  // ---------------- stage C: data row ready, write back --------------------
  logic             c_valid_r, c_wen_r, c_load_r, c_store_r, c_sign_r;
  logic [4:0]       c_waddr_r;
  logic [31:0]      c_alu_r, c_bdata_r;
  logic [1:0]       c_size_r, c_off_r;
  logic [ROW_AW-1:0] c_row_r;
  out_item_t        c_out_r;

  // data memory: 32-bit big-endian rows, byte 0 in the top lane
  logic [31:0]       dm_mem [ROWS];
  logic [ROWS-1:0]   dm_vld_r;
  logic [31:0]       dm_q, dm_bdat_r;
  logic              dm_v_r, dm_byp_r;
  logic              dm_we;
  logic [31:0]       dm_wdata;

  // stage B combinational results
  logic [31:0] op_a, op_b, a_rf, b_rf;
  logic [31:0] si, zi, pc4, br_tgt, j_tgt, ea, res, npc, lim;
  logic        wen, wz, nov, aov, mis, is_ld, is_st, sgn, fault;
  logic [4:0]  waddr;
  logic [1:0]  size;
  logic [2:0]  nbytes;
  logic [ROW_AW-1:0] b_row;
  out_item_t   b_out;

  assign rf_we = advance && c_valid_r && c_wen_r;
  assign dm_we = advance && c_valid_r && c_store_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      rf_a_q   <= rf_mem[in_ch.data.src_reg];
      rf_b_q   <= rf_mem[in_ch.data.tgt_reg];
      a_vld_r  <= rf_vld_r[in_ch.data.src_reg];
      b_vld_r  <= rf_vld_r[in_ch.data.tgt_reg];
      // catch the write that lands on the same edge as the read
      a_byp_r  <= rf_we && (c_waddr_r == in_ch.data.src_reg);
      b_byp_r  <= rf_we && (c_waddr_r == in_ch.data.tgt_reg);
      a_bdat_r <= rf_wdata;
      b_bdat_r <= rf_wdata;
    end
    if (rf_we) begin
      rf_mem[c_waddr_r] <= rf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[c_waddr_r] <= 1'b1;
    end
  end

  // ---------------- stage B ------------------------------------------------
  assign a_rf = a_byp_r ? a_bdat_r : (a_vld_r ? rf_a_q : 32'd0);
  assign b_rf = b_byp_r ? b_bdat_r : (b_vld_r ? rf_b_q : 32'd0);
  // forward the pending write back of stage C
  assign op_a = (c_valid_r && c_wen_r && c_waddr_r == b_item_r.src_reg) ? rf_wdata : a_rf;
  assign op_b = (c_valid_r && c_wen_r && c_waddr_r == b_item_r.tgt_reg) ? rf_wdata : b_rf;

  assign si     = {{16{b_item_r.immediate[15]}}, b_item_r.immediate[15:0]};
  assign zi     = {16'd0, b_item_r.immediate[15:0]};
  assign pc4    = pc_r + 32'd4;
  assign br_tgt = pc4 + {si[29:0], 2'b00};
  assign j_tgt  = {pc4[31:28], b_item_r.immediate, 2'b00};
  assign ea     = op_a + si;
  assign nbytes = (size == SZ_WORD) ? 3'd4 : ((size == SZ_HALF) ? 3'd2 : 3'd1);
  assign lim    = 32'(MEM_BYTES) - {29'd0, nbytes};
  assign b_row  = ea[MEM_AW-1:2];

  always_comb begin
    logic [31:0] sum;
    sum   = op_a + op_b;
    res   = 32'd0;
    wen   = 1'b0;
    waddr = b_item_r.dst_reg;
    nov   = 1'b0;
    aov   = 1'b0;
    mis   = 1'b0;
    is_ld = 1'b0;
    is_st = 1'b0;
    sgn   = 1'b0;
    size  = SZ_WORD;
    npc   = pc4;
    case (b_item_r.op)
      OP_ADD: begin
        res = sum; wen = 1'b1;
        nov = ~(op_a[31] ^ op_b[31]) & (op_a[31] ^ sum[31]);
      end
      OP_ADDU: begin res = sum; wen = 1'b1; end
      OP_SUB: begin
        res = op_a - op_b; wen = 1'b1;
        nov = (op_a[31] ^ op_b[31]) & (op_a[31] ^ res[31]);
      end
      OP_AND:  begin res = op_a & op_b; wen = 1'b1; end
      OP_OR:   begin res = op_a | op_b; wen = 1'b1; end
      OP_XOR:  begin res = op_a ^ op_b; wen = 1'b1; end
      OP_NOR:  begin res = ~(op_a | op_b); wen = 1'b1; end
      OP_NAND: begin res = ~(op_a & op_b); wen = 1'b1; end
      OP_SLT: begin
        res = {31'd0, $signed(op_a) < $signed(op_b)}; wen = 1'b1;
      end
      OP_SLL: begin res = op_b << b_item_r.shift_amount; wen = 1'b1; end
      OP_SRL: begin res = op_b >> b_item_r.shift_amount; wen = 1'b1; end
      OP_SRA: begin
        res = 32'($signed(op_b) >>> b_item_r.shift_amount); wen = 1'b1;
      end
      OP_JR: npc = op_a;
      OP_ADDI: begin
        res = ea; wen = 1'b1; waddr = b_item_r.tgt_reg;
        nov = ~(op_a[31] ^ si[31]) & (op_a[31] ^ ea[31]);
      end
      OP_ADDIU: begin res = ea; wen = 1'b1; waddr = b_item_r.tgt_reg; end
      OP_LW:  begin is_ld = 1'b1; size = SZ_WORD; end
      OP_LH:  begin is_ld = 1'b1; size = SZ_HALF; sgn = 1'b1; end
      OP_LHU: begin is_ld = 1'b1; size = SZ_HALF; end
      OP_LB:  begin is_ld = 1'b1; size = SZ_BYTE; sgn = 1'b1; end
      OP_LBU: begin is_ld = 1'b1; size = SZ_BYTE; end
      OP_SW:  begin is_st = 1'b1; size = SZ_WORD; end
      OP_SH:  begin is_st = 1'b1; size = SZ_HALF; end
      OP_SB:  begin is_st = 1'b1; size = SZ_BYTE; end
      OP_LUI:  begin res = {b_item_r.immediate[15:0], 16'd0}; wen = 1'b1;
                     waddr = b_item_r.tgt_reg; end
      OP_ANDI: begin res = op_a & zi; wen = 1'b1; waddr = b_item_r.tgt_reg; end
      OP_ORI:  begin res = op_a | zi; wen = 1'b1; waddr = b_item_r.tgt_reg; end
      OP_NORI: begin res = ~(op_a | zi); wen = 1'b1; waddr = b_item_r.tgt_reg; end
      OP_SLTI: begin
        res = {31'd0, $signed(op_a) < $signed(si)}; wen = 1'b1;
        waddr = b_item_r.tgt_reg;
      end
      OP_BEQ:  if (op_a == op_b) npc = br_tgt;
      OP_BNE:  if (op_a != op_b) npc = br_tgt;
      OP_BGTZ: if (op_a != 32'd0 && !op_a[31]) npc = br_tgt;
      OP_J:    npc = j_tgt;
      OP_JAL: begin res = pc4; wen = 1'b1; waddr = REG_LINK; npc = j_tgt; end
      default: ;
    endcase
    if (is_ld || is_st) begin
      waddr = b_item_r.tgt_reg;
      wen   = is_ld;
      nov   = ~(op_a[31] ^ si[31]) & (op_a[31] ^ ea[31]);
      aov   = ea[31] || (ea > lim);
      mis   = ((size == SZ_WORD) && (ea[1:0] != 2'd0)) ||
              ((size == SZ_HALF) && ea[0]);
    end
    // register zero: flag and drop (jal targets the link register)
    wz = wen && (waddr == 5'd0);
    fault = aov || mis;
    if (fault) begin
      npc = pc_r;
      wen = 1'b0;
      is_ld = 1'b0;
      is_st = 1'b0;
    end
    if (wz) begin
      wen = 1'b0;
    end
    b_out.next_pc          = npc;
    b_out.write_zero_error = wz;
    b_out.number_overflow  = nov;
    b_out.address_overflow = aov;
    b_out.misaligned       = mis;
    b_out.halt             = fault;
    if (halted_r) begin
      // halted: change nothing, answer the held PC
      npc   = pc_r;
      wen   = 1'b0;
      is_ld = 1'b0;
      is_st = 1'b0;
      fault = 1'b0;
      b_out = '{next_pc: pc_r, write_zero_error: 1'b0, number_overflow: 1'b0,
                address_overflow: 1'b0, misaligned: 1'b0, halt: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r  <= 1'b0;
      c_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r       <= 32'd0;
      start_pc_r <= 32'd0;
      halted_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        start_pc_r <= pwdata;
        pc_r       <= pwdata;
      end else if (advance && b_valid_r) begin
        pc_r     <= npc;
        halted_r <= halted_r || fault;
      end
      if (advance) begin
        b_valid_r   <= in_ch.valid;
        c_valid_r   <= b_valid_r;
        out_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_item_r  <= in_ch.data;
      c_wen_r   <= wen;
      c_waddr_r <= waddr;
      c_alu_r   <= res;
      c_load_r  <= is_ld;
      c_store_r <= is_st;
      c_sign_r  <= sgn;
      c_size_r  <= size;
      c_off_r   <= ea[1:0];
      c_row_r   <= b_row;
      c_bdata_r <= op_b;
      c_out_r   <= b_out;
      out_data_r <= c_out_r;
    end
  end

  // ---------------- data memory --------------------------------------------
  always_ff @(posedge clk) begin
    if (advance) begin
      dm_q      <= dm_mem[b_row];
      dm_v_r    <= dm_vld_r[b_row];
      dm_byp_r  <= dm_we && (c_row_r == b_row);
      dm_bdat_r <= dm_wdata;
    end
    if (dm_we) begin
      dm_mem[c_row_r] <= dm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dm_vld_r <= '0;
    end else if (dm_we) begin
      dm_vld_r[c_row_r] <= 1'b1;
    end
  end

  // ---------------- stage C: load extract, store merge ---------------------
  always_comb begin
    logic [31:0] row;
    logic [15:0] half;
    logic [7:0]  byt;
    logic [31:0] ldv;
    row  = dm_byp_r ? dm_bdat_r : (dm_v_r ? dm_q : 32'd0);
    half = c_off_r[1] ? row[15:0] : row[31:16];
    case (c_off_r)
      2'd0:    byt = row[31:24];
      2'd1:    byt = row[23:16];
      2'd2:    byt = row[15:8];
      default: byt = row[7:0];
    endcase
    case (c_size_r)
      SZ_WORD: ldv = row;
      SZ_HALF: ldv = {{16{c_sign_r & half[15]}}, half};
      default: ldv = {{24{c_sign_r & byt[7]}}, byt};
    endcase
    rf_wdata = c_load_r ? ldv : c_alu_r;
    dm_wdata = row;
    case (c_size_r)
      SZ_WORD: dm_wdata = c_bdata_r;
      SZ_HALF: begin
        if (c_off_r[1]) dm_wdata[15:0] = c_bdata_r[15:0];
        else            dm_wdata[31:16] = c_bdata_r[15:0];
      end
      default: begin
        case (c_off_r)
          2'd0:    dm_wdata[31:24] = c_bdata_r[7:0];
          2'd1:    dm_wdata[23:16] = c_bdata_r[7:0];
          2'd2:    dm_wdata[15:8]  = c_bdata_r[7:0];
          default: dm_wdata[7:0]   = c_bdata_r[7:0];
        endcase
      end
    endcase
  end

  // ---------------- assertions ---------------------------------------------
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halt cleared without reset");
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && c_wen_r |-> c_waddr_r != 5'd0) else $error("write to r0");
  a_r0_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    !rf_vld_r[0]) else $error("r0 marked written");
  a_store_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && c_store_r |-> !c_wen_r) else $error("store with write back");

endmodule
